// ----- rtl/plt_pkg.sv -----
// Shared types and constants for the packet latency timestamp table.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none
package plt_pkg;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [15:0] FIRST_PORT_RST  = 16'd4999;
	localparam logic [15:0] SECOND_PORT_RST = 16'd5000;

	localparam logic [2:0] STATUS_IGNORED  = 3'd0;
	localparam logic [2:0] STATUS_RECORDED = 3'd1;
	localparam logic [2:0] STATUS_RANGE    = 3'd2;
	localparam logic [2:0] STATUS_EMPTY    = 3'd3;
	localparam logic [2:0] STATUS_MEASURED = 3'd4;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// What the back end has to do with a classified packet.
	typedef enum logic [1:0] {
		KIND_IGNORE = 2'd0,
		KIND_RANGE  = 2'd1,
		KIND_RECORD = 2'd2,
		KIND_FETCH  = 2'd3
	} item_kind_t;

	typedef struct packed {
		item_kind_t   kind;
		logic         cls;
		logic [31:0]  pidx;
		logic [63:0]  ts;
	} item_t;

endpackage
`default_nettype wire

// ----- rtl/plt_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none
module plt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16384,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ----- rtl/plt_front.sv -----
// Front end: qualifies each accepted packet header and classifies it for the back end.
// Depends on plt_pkg.
`default_nettype none
module plt_front import plt_pkg::*; #(
	parameter int TABLE_DEPTH = 16384
) (
	input  wire logic        accept,
	input  wire logic        action,
	input  wire logic [15:0] ethertype,
	input  wire logic [7:0]  ip_protocol,
	input  wire logic [15:0] src_port,
	input  wire logic [15:0] dst_port,
	input  wire logic [31:0] seq_index,
	input  wire logic [63:0] timestamp,
	input  wire logic [15:0] first_port,
	input  wire logic [15:0] second_port,
	output logic             push,
	output item_t            push_item
);

	logic port_hit;
	logic qualify;
	logic in_range;

	assign port_hit = (src_port == first_port) || (dst_port == first_port) ||
	                  (src_port == second_port) || (dst_port == second_port);
	assign qualify  = (ethertype == ETHERTYPE_IPV4) && (ip_protocol == PROTO_UDP) && port_hit;
	assign in_range = seq_index < 32'(TABLE_DEPTH);

	always_comb begin
		push_item.ts = timestamp;
		if (!qualify) begin
			push_item.kind = KIND_IGNORE;
			push_item.cls  = 1'b0;
			push_item.pidx = '0;
		end else begin
			push_item.cls  = (dst_port != first_port);
			push_item.pidx = seq_index;
			if (!in_range) begin
				push_item.kind = KIND_RANGE;
			end else if (action) begin
				push_item.kind = KIND_FETCH;
			end else begin
				push_item.kind = KIND_RECORD;
			end
		end
	end

	assign push = accept;

endmodule
`default_nettype wire

// ----- rtl/plt_queue.sv -----
// Short FIFO of classified items between the front end and the back end.
// Depends on plt_pkg.
`default_nettype none
module plt_queue import plt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  item_t      push_item,
	input  wire logic  pop,
	output item_t      head_item,
	output logic       empty,
	output logic       full
);

	item_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;

	assign empty     = (count_q == '0);
	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/plt_back.sv -----
// Back end: clears the timestamp table after reset, then executes queued items
// against it and registers one result per item. Depends on plt_pkg and plt_ram.
`default_nettype none
module plt_back import plt_pkg::*; #(
	parameter int TABLE_DEPTH = 16384,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  item_t            head_item,
	input  wire logic        empty,
	output logic             pop,
	output logic             clearing,
	output logic             done,
	output logic [2:0]       status,
	output logic             traffic_class,
	output logic [31:0]      packet_index,
	output logic [63:0]      stored_time,
	output logic [63:0]      latency
);

	typedef enum logic [2:0] {
		BK_CLEAR = 3'b001,
		BK_IDLE  = 3'b010,
		BK_READ  = 3'b100
	} back_state_t;

	back_state_t     state_q, state_d;
	logic [AW-1:0]   clr_q;
	item_t           cur_q;

	logic            wr_en, rd_en;
	logic [AW-1:0]   wr_addr, rd_addr;
	logic [63:0]     wr_data, rd_data;

	logic            emit;
	logic [2:0]      res_status;
	logic            res_cls;
	logic [31:0]     res_pidx;
	logic [63:0]     res_start, res_lat;

	logic            done_q;
	logic [2:0]      status_q;
	logic            cls_q;
	logic [31:0]     pidx_q;
	logic [63:0]     start_q, lat_q;

	plt_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = head_item.pidx[AW-1:0];
		wr_data    = '0;
		rd_en      = 1'b0;
		rd_addr    = head_item.pidx[AW-1:0];
		emit       = 1'b0;
		res_status = STATUS_IGNORED;
		res_cls    = head_item.cls;
		res_pidx   = head_item.pidx;
		res_start  = '0;
		res_lat    = '0;
		unique case (state_q)
			BK_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				if (clr_q == AW'(TABLE_DEPTH-1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					case (head_item.kind)
						KIND_IGNORE: begin
							emit       = 1'b1;
							res_status = STATUS_IGNORED;
						end
						KIND_RANGE: begin
							emit       = 1'b1;
							res_status = STATUS_RANGE;
						end
						KIND_RECORD: begin
							emit       = 1'b1;
							res_status = STATUS_RECORDED;
							wr_en      = 1'b1;
							wr_data    = head_item.ts;
						end
						KIND_FETCH: begin
							rd_en   = 1'b1;
							state_d = BK_READ;
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			BK_READ: begin
				// The stored time arrives in the cycle after the read was issued.
				emit     = 1'b1;
				res_cls  = cur_q.cls;
				res_pidx = cur_q.pidx;
				state_d  = BK_IDLE;
				if (rd_data == '0) begin
					res_status = STATUS_EMPTY;
				end else begin
					res_status = STATUS_MEASURED;
					res_start  = rd_data;
					res_lat    = cur_q.ts - rd_data;
					wr_en      = 1'b1;
					wr_addr    = cur_q.pidx[AW-1:0];
				end
			end
			default: begin
				state_d = BK_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cur_q <= head_item;
		end
		if (emit) begin
			status_q <= res_status;
			cls_q    <= res_cls;
			pidx_q   <= res_pidx;
			start_q  <= res_start;
			lat_q    <= res_lat;
		end
	end

	assign clearing      = (state_q == BK_CLEAR);
	assign done          = done_q;
	assign status        = status_q;
	assign traffic_class = cls_q;
	assign packet_index  = pidx_q;
	assign stored_time   = start_q;
	assign latency       = lat_q;

endmodule
`default_nettype wire

// ----- rtl/packet_latency_timestamp_table.sv -----
// Top level of the packet latency timestamp table: APB registers, front end,
// item queue and back end. Depends on plt_pkg, plt_front, plt_queue and plt_back.
`default_nettype none
// A packet header is taken when start is high and busy is low. After reset the
// block holds busy high while it zeroes the timestamp memory, one entry per cycle.
// Accepted items enter a two-entry queue; the back end then handles an ignored,
// out-of-range or arrival packet in its idle state, and a delivery packet in its
// idle state and then its read state, which waits on the registered read of the
// timestamp memory. A result is presented with done high for exactly one cycle;
// it is registered after the back end takes the item from the queue (after the
// read state for a delivery packet), and the receiver cannot stall it. busy rises
// only while the queue is full or the clearing pass runs.
module packet_latency_timestamp_table import plt_pkg::*; #(
	parameter int TABLE_DEPTH = 16384
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        action,
	input  wire logic [15:0] ethertype,
	input  wire logic [7:0]  ip_protocol,
	input  wire logic [15:0] src_port,
	input  wire logic [15:0] dst_port,
	input  wire logic [31:0] seq_index,
	input  wire logic [63:0] timestamp,
	output logic             done,
	output logic [2:0]       status,
	output logic             traffic_class,
	output logic [31:0]      packet_index,
	output logic [63:0]      stored_time,
	output logic [63:0]      latency
);

	localparam logic REG_FIRST_PORT  = 1'b0;
	localparam logic REG_SECOND_PORT = 1'b1;

	logic [15:0] first_port_q;
	logic [15:0] second_port_q;
	logic        cfg_wr;
	logic        accept;
	logic        push, pop, empty, full, clearing;
	item_t       push_item, head_item;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_port_q  <= FIRST_PORT_RST;
			second_port_q <= SECOND_PORT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FIRST_PORT:  first_port_q  <= pwdata[15:0];
				REG_SECOND_PORT: second_port_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FIRST_PORT:  prdata = {16'h0, first_port_q};
			REG_SECOND_PORT: prdata = {16'h0, second_port_q};
			default:         prdata = '0;
		endcase
	end

	assign busy   = clearing || full;
	assign accept = start && !busy;

	plt_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
		.accept      (accept),
		.action      (action),
		.ethertype   (ethertype),
		.ip_protocol (ip_protocol),
		.src_port    (src_port),
		.dst_port    (dst_port),
		.seq_index   (seq_index),
		.timestamp   (timestamp),
		.first_port  (first_port_q),
		.second_port (second_port_q),
		.push        (push),
		.push_item   (push_item)
	);

	plt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.empty     (empty),
		.full      (full)
	);

	plt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_item     (head_item),
		.empty         (empty),
		.pop           (pop),
		.clearing      (clearing),
		.done          (done),
		.status        (status),
		.traffic_class (traffic_class),
		.packet_index  (packet_index),
		.stored_time   (stored_time),
		.latency       (latency)
	);

endmodule
`default_nettype wire
